>>> rtl/core/ile_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_pkg: shared definitions for the indexed list engine
// Sizes, operation codes and the structs that pass between the list cells
// and the controller.
// ----------------------------------------------------------------------------
package ile_pkg;

    // List capacity and the widths derived from it.
    localparam int DEPTH   = 64;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int MODE_W  = 3;
    localparam int POS_W   = 7;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 7;
    // Width in which positions, counts and cell indexes are compared.
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Operation codes carried in the mode field.
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH   = 3'd0,
        MODE_POP    = 3'd1,
        MODE_INSERT = 3'd2,
        MODE_REMOVE = 3'd3,
        MODE_READ   = 3'd4,
        MODE_WRITE  = 3'd5,
        MODE_SEARCH = 3'd6
    } t_mode;

    // Update broadcast to every cell for one cycle.
    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SHIFT_UP,
        CMD_SHIFT_DOWN
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [CMP_W-1:0]   pos;
        logic [DATA_W-1:0]  value;
    } t_cmd;

    // Probe that travels along the chain, one cell per cycle.
    typedef struct packed {
        logic               valid;
        logic               search;
        logic               fetch;
        logic [CMP_W-1:0]   tgt;
        logic [CMP_W-1:0]   limit;
        logic [DATA_W-1:0]  key;
        logic               found;
        logic [DATA_W-1:0]  data;
    } t_probe;

endpackage

>>> rtl/core/ile_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_if: channel interfaces of the indexed list engine
// One interface for operation requests and one for results, each with a
// valid/ready handshake and its payload.
// ----------------------------------------------------------------------------
interface ile_in_if;
    import ile_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output mode, output position, output value, input ready);
    modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

interface ile_out_if;
    import ile_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic                     found;
    logic [COUNT_W-1:0]       count;

    modport source (output valid, output ok, output read_value, output found, output count,
                    input ready);
    modport sink   (input valid, input ok, input read_value, input found, input count,
                    output ready);
endinterface

>>> rtl/core/ile_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_cell: one list entry
// Holds one word, applies the broadcast update using its neighbours' words,
// and passes the travelling probe on to the next cell.
// ----------------------------------------------------------------------------
module ile_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [ile_pkg::CMP_W-1:0]    i_index,
    input  ile_pkg::t_cmd                i_cmd,
    input  logic [ile_pkg::DATA_W-1:0]   i_left,
    input  logic [ile_pkg::DATA_W-1:0]   i_right,
    output logic [ile_pkg::DATA_W-1:0]   o_entry,
    input  ile_pkg::t_probe              i_probe,
    output ile_pkg::t_probe              o_probe
);
    import ile_pkg::*;

    logic [DATA_W-1:0] r_entry;
    logic [DATA_W-1:0] n_entry;
    t_probe            r_probe;
    t_probe            n_probe;

    // Entry update: load at the position, or shift towards either end.
    always_comb begin
        n_entry = r_entry;
        case (i_cmd.kind)
            CMD_LOAD: begin
                if (i_index == i_cmd.pos) n_entry = i_cmd.value;
            end
            CMD_SHIFT_UP: begin
                if (i_index == i_cmd.pos) begin
                    n_entry = i_cmd.value;
                end else if (i_index > i_cmd.pos) begin
                    n_entry = i_left;
                end
            end
            CMD_SHIFT_DOWN: begin
                if (i_index >= i_cmd.pos) n_entry = i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    // Probe: compare for a search and pick up the word for a fetch.
    always_comb begin
        n_probe = i_probe;
        if (i_probe.search && (i_index < i_probe.limit) && (r_entry == i_probe.key)) begin
            n_probe.found = 1'b1;
        end
        if (i_probe.fetch && (i_index == i_probe.tgt)) begin
            n_probe.data = r_entry;
        end
    end

    // The word needs no reset; only the probe is cleared.
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
        end
    end

    assign o_entry = r_entry;
    assign o_probe = r_probe;

endmodule

>>> rtl/core/ile_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_ctrl: sequencer of the indexed list engine
// Takes one operation at a time, checks it against the fill count, issues
// the cell update or launches a probe, and delivers the result.
// ----------------------------------------------------------------------------
module ile_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ile_in_if.sink           i_in,
    ile_out_if.source        o_out,
    output ile_pkg::t_cmd    o_cmd,
    output ile_pkg::t_probe  o_probe,
    input  ile_pkg::t_probe  i_probe_end
);
    import ile_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SWEEP,
        S_FINISH
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_fill;
    logic [MODE_W-1:0]  r_mode;
    logic [POS_W-1:0]   r_pos;
    logic [DATA_W-1:0]  r_val;

    // Pending result.
    logic               r_res_ok;
    logic [DATA_W-1:0]  r_res_rd;
    logic               r_res_found;
    logic [COUNT_W-1:0] r_res_count;

    // Output register.
    logic               r_out_valid;
    logic               r_out_ok;
    logic [DATA_W-1:0]  r_out_rd;
    logic               r_out_found;
    logic [COUNT_W-1:0] r_out_count;

    logic [CMP_W-1:0]   w_fill_c;
    logic [CMP_W-1:0]   w_pos_c;
    logic               w_full;
    logic               w_out_load;
    logic               n_ok;
    logic [CNT_W-1:0]   n_fill;
    logic               n_use_probe;
    t_cmd               n_cmd;
    t_probe             n_probe;

    assign w_fill_c = CMP_W'(r_fill);
    assign w_pos_c  = CMP_W'(r_pos);
    assign w_full   = (w_fill_c >= CMP_W'(DEPTH));

    // A finished result moves to the output register once that is free.
    assign w_out_load = (r_state == S_FINISH) && (!r_out_valid || o_out.ready);

    // Decode of the held operation against the current fill count.
    always_comb begin
        n_ok          = 1'b0;
        n_fill        = r_fill;
        n_use_probe   = 1'b0;
        n_cmd.kind    = CMD_NONE;
        n_cmd.pos     = w_pos_c;
        n_cmd.value   = r_val;
        n_probe.valid  = 1'b0;
        n_probe.search = 1'b0;
        n_probe.fetch  = 1'b0;
        n_probe.tgt    = w_pos_c;
        n_probe.limit  = w_fill_c;
        n_probe.key    = r_val;
        n_probe.found  = 1'b0;
        n_probe.data   = '0;
        case (t_mode'(r_mode))
            MODE_PUSH: begin
                if (!w_full) begin
                    n_ok       = 1'b1;
                    n_fill     = r_fill + CNT_W'(1);
                    n_cmd.kind = CMD_LOAD;
                    n_cmd.pos  = w_fill_c;
                end
            end
            MODE_POP: begin
                if (r_fill != '0) begin
                    n_ok          = 1'b1;
                    n_fill        = r_fill - CNT_W'(1);
                    n_use_probe   = 1'b1;
                    n_probe.fetch = 1'b1;
                    n_probe.tgt   = w_fill_c - CMP_W'(1);
                end
            end
            MODE_INSERT: begin
                if (!w_full && (w_pos_c <= w_fill_c)) begin
                    n_ok       = 1'b1;
                    n_fill     = r_fill + CNT_W'(1);
                    n_cmd.kind = CMD_SHIFT_UP;
                end
            end
            MODE_REMOVE: begin
                if (w_pos_c < w_fill_c) begin
                    n_ok       = 1'b1;
                    n_fill     = r_fill - CNT_W'(1);
                    n_cmd.kind = CMD_SHIFT_DOWN;
                end
            end
            MODE_READ: begin
                if (w_pos_c < w_fill_c) begin
                    n_ok          = 1'b1;
                    n_use_probe   = 1'b1;
                    n_probe.fetch = 1'b1;
                end
            end
            MODE_WRITE: begin
                if (w_pos_c < w_fill_c) begin
                    n_ok       = 1'b1;
                    n_cmd.kind = CMD_LOAD;
                end
            end
            MODE_SEARCH: begin
                n_ok           = 1'b1;
                n_use_probe    = 1'b1;
                n_probe.search = 1'b1;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
        n_probe.valid = n_use_probe;
    end

    // Broadcasts are live only in the execute cycle.
    always_comb begin
        o_cmd   = n_cmd;
        o_probe = n_probe;
        if (r_state != S_EXEC) begin
            o_cmd.kind    = CMD_NONE;
            o_probe.valid = 1'b0;
        end
    end

    // State, fill count, held operation and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The output register fills from the finish state and empties on a transfer.
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_mode  <= i_in.mode;
                        r_pos   <= i_in.position;
                        r_val   <= i_in.value;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_fill      <= n_fill;
                    r_res_ok    <= n_ok;
                    r_res_rd    <= '0;
                    r_res_found <= 1'b0;
                    r_res_count <= COUNT_W'(n_fill);
                    r_state     <= n_use_probe ? S_SWEEP : S_FINISH;
                end
                S_SWEEP: begin
                    if (i_probe_end.valid) begin
                        r_res_rd    <= i_probe_end.data;
                        r_res_found <= i_probe_end.found;
                        r_state     <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_out_load) begin
                        r_out_ok    <= r_res_ok;
                        r_out_rd    <= r_res_rd;
                        r_out_found <= r_res_found;
                        r_out_count <= r_res_count;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.ok         = r_out_ok;
    assign o_out.read_value = r_out_rd;
    assign o_out.found      = r_out_found;
    assign o_out.count      = r_out_count;

endmodule

>>> rtl/core/indexed_list_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_engine_unit: fixed-capacity ordered list of signed words
// Push, pop, insert, remove, read, write and search over a chain of cells,
// one list entry to a cell, driven by a sequencer.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                             Transfer when
//  i_in      in         mode, position, value               valid && ready
//  o_out     out        ok, read_value, found, count        valid && ready
//
//  Push, insert, remove, write and refused operations pass through the
//  execute and finish states; read, pop and search also wait in the sweep
//  state for the probe that walks the cell chain one cell per cycle.
//  Reset is synchronous and active low; it empties the list at once.
//  A result waiting in the output register does not hold off the next
//  request; a stalled output only blocks the item after it from finishing.
// ----------------------------------------------------------------------------
module indexed_list_engine_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ile_in_if.sink     i_in,
    ile_out_if.source  o_out
);
    import ile_pkg::*;

    t_cmd              w_cmd;
    t_probe            w_probe [DEPTH+1];
    logic [DATA_W-1:0] w_entry [DEPTH];

    // Sequencer.
    ile_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_cmd       (w_cmd),
        .o_probe     (w_probe[0]),
        .i_probe_end (w_probe[DEPTH])
    );

    // Chain of list cells; the end cells see their own word as the
    // missing neighbour.
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;

        if (gi == 0) begin : g_first
            assign w_left = w_entry[gi];
        end else begin : g_mid_l
            assign w_left = w_entry[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_last
            assign w_right = w_entry[gi];
        end else begin : g_mid_r
            assign w_right = w_entry[gi+1];
        end

        ile_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (CMP_W'(gi)),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[gi]),
            .i_probe (w_probe[gi]),
            .o_probe (w_probe[gi+1])
        );
    end

endmodule
